/* hdl/qsr_pkg.sv */
// qsr_pkg: request kind codes and the structs passed between the span rasterizer blocks.
// No dependencies.
package qsr_pkg;

   localparam int COORD_W = 8;

   localparam logic [1:0] KIND_BEGIN = 2'd0;
   localparam logic [1:0] KIND_EDGE  = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // one Bresenham point from the line walker
   typedef struct packed {
      logic               vld;
      logic               last;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } point_type;

   // address and update request into the span store
   typedef struct packed {
      logic               update;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } probe_type;

   // merged span of the row sitting in the store's data stage
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] left;
      logic signed [8:0]  right;
      logic               drawn;
   } span_type;

endpackage

/* hdl/qsr_ram.sv */
// qsr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module qsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 132
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/qsr_line_walker.sv */
// qsr_line_walker: Bresenham point generator, one point per cycle from start to end.
// Depends on qsr_pkg.
module qsr_line_walker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [7:0]         start_x,
   input  logic [7:0]         start_y,
   input  logic [7:0]         end_x,
   input  logic [7:0]         end_y,
   output qsr_pkg::point_type point
);
   import qsr_pkg::*;

   logic              active_ff;
   logic [7:0]        x_ff, y_ff, xe_ff, ye_ff;
   logic [7:0]        dx_ff, dy_ff;
   logic              x_neg_ff, y_neg_ff;
   logic signed [9:0] err_ff;

   logic [7:0]         dx_in, dy_in;
   logic signed [10:0] e2;
   logic               at_end, move_x, move_y;
   logic signed [9:0]  err_in;
   logic [7:0]         x_in, y_in;

   assign dx_in  = (start_x > end_x) ? start_x - end_x : end_x - start_x;
   assign dy_in  = (start_y > end_y) ? start_y - end_y : end_y - start_y;
   assign at_end = (x_ff == xe_ff) && (y_ff == ye_ff);

   // e2 = 2*err, compared against -dy and dx
   assign e2     = {err_ff, 1'b0};
   assign move_x = e2 > -$signed({3'b000, dy_ff});
   assign move_y = e2 < $signed({3'b000, dx_ff});

   always_comb begin
      err_in = err_ff;
      if (move_x) begin
         err_in = err_in - $signed({2'b00, dy_ff});
      end
      if (move_y) begin
         err_in = err_in + $signed({2'b00, dx_ff});
      end
      x_in = x_ff;
      if (move_x) begin
         x_in = x_neg_ff ? x_ff - 8'd1 : x_ff + 8'd1;
      end
      y_in = y_ff;
      if (move_y) begin
         y_in = y_neg_ff ? y_ff - 8'd1 : y_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (start) begin
         active_ff <= 1'b1;
      end else if (active_ff && at_end) begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff     <= start_x;
         y_ff     <= start_y;
         xe_ff    <= end_x;
         ye_ff    <= end_y;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         x_neg_ff <= start_x > end_x;
         y_neg_ff <= start_y > end_y;
         err_ff   <= $signed({2'b00, dx_in}) - $signed({2'b00, dy_in});
      end else if (active_ff && !at_end) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         err_ff <= err_in;
      end
   end

   assign point.vld  = active_ff;
   assign point.last = active_ff && at_end;
   assign point.row  = y_ff;
   assign point.col  = x_ff;

endmodule

/* hdl/qsr_span_store.sv */
// qsr_span_store: left/right span RAMs with per-row valid bits, read-modify-write
// of one point per cycle while hold is low and forwarding of the previous write. Depends on qsr_pkg, qsr_ram.
module qsr_span_store #(
   parameter int ROWS = 132,
   parameter int COLS = 132
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               hold,
   input  qsr_pkg::probe_type probe,
   output qsr_pkg::span_type  span
);
   import qsr_pkg::*;

   localparam int AW = $clog2(ROWS);
   localparam logic [7:0]        LeftInit  = 8'(COLS + 1);
   localparam logic signed [8:0] RightInit = -9'sd1;
   localparam logic [8:0]        RightMax  = 9'(ROWS - 1);

   probe_type         stage_ff, stage_in;
   logic [ROWS-1:0]   valid_ff;
   logic              fwd_vld_ff;
   logic [AW-1:0]     fwd_row_ff;
   logic [7:0]        fwd_left_ff;
   logic signed [8:0] fwd_right_ff;

   logic [AW-1:0]     rd_addr, sidx;
   logic [7:0]        rd_left;
   logic [8:0]        rd_right;
   logic              stage_in_rng, row_live, fwd_hit, wr_en;
   logic [7:0]        cur_left, new_left;
   logic signed [8:0] cur_right, new_right, col_s;

   always_comb begin
      stage_in        = probe;
      stage_in.update = probe.update && ({1'b0, probe.row} < 9'(ROWS));
   end

   // while held the stage keeps its row, so the read data stays put
   assign rd_addr = hold ? stage_ff.row[AW-1:0] : probe.row[AW-1:0];
   assign sidx    = stage_ff.row[AW-1:0];

   assign stage_in_rng = {1'b0, stage_ff.row} < 9'(ROWS);
   assign row_live     = stage_in_rng && valid_ff[sidx];
   assign fwd_hit      = fwd_vld_ff && (fwd_row_ff == sidx);

   always_comb begin
      if (fwd_hit) begin
         cur_left  = fwd_left_ff;
         cur_right = fwd_right_ff;
      end else if (row_live) begin
         cur_left  = rd_left;
         cur_right = $signed(rd_right);
      end else begin
         cur_left  = LeftInit;
         cur_right = RightInit;
      end
   end

   assign col_s     = $signed({1'b0, stage_ff.col});
   assign new_left  = (stage_ff.col < cur_left) ? stage_ff.col : cur_left;
   assign new_right = (col_s > cur_right) ?
                      ((stage_ff.col < 8'(ROWS)) ? col_s : $signed(RightMax)) : cur_right;
   assign wr_en     = stage_ff.update;

   qsr_ram #(.WIDTH(8), .DEPTH(ROWS)) u_left_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (sidx),
      .wr_data (new_left),
      .rd_addr (rd_addr),
      .rd_data (rd_left)
   );

   qsr_ram #(.WIDTH(9), .DEPTH(ROWS)) u_right_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (sidx),
      .wr_data (new_right),
      .rd_addr (rd_addr),
      .rd_data (rd_right)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff   <= '0;
         valid_ff   <= '0;
         fwd_vld_ff <= 1'b0;
      end else begin
         if (!hold) begin
            stage_ff <= stage_in;
         end
         if (clear) begin
            valid_ff   <= '0;
            fwd_vld_ff <= 1'b0;
         end else if (wr_en) begin
            valid_ff[sidx] <= 1'b1;
            fwd_vld_ff     <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_row_ff   <= sidx;
         fwd_left_ff  <= new_left;
         fwd_right_ff <= new_right;
      end
   end

   assign span.row   = stage_ff.row;
   assign span.left  = cur_left;
   assign span.right = cur_right;
   assign span.drawn = cur_right > $signed({1'b0, cur_left});

endmodule

/* hdl/quad_span_rasterizer.sv */
// quad_span_rasterizer: top level, request sequencer and response register.
// Depends on qsr_pkg, qsr_line_walker, qsr_span_store.
//
// Per-row span builder for polygon fill. A begin request drops every row's valid
// bit (untouched rows read as left COLS+1, right -1) and latches the color. An edge
// request walks N Bresenham points (max(|dx|,|dy|)+1, at most 256): the span RAMs
// do one read-modify-write per point, so one point retires per cycle; the walker
// is loaded first and S_DRAIN finishes the last write. A read request waits in
// S_READ while the previous response has not been taken; a read of a row at or
// beyond ROWS gives no response. No clearing pass follows reset. One request is
// worked on at a time; the response register lets the next request in while a
// result waits.
module quad_span_rasterizer #(
   parameter int ROWS = 132,
   parameter int COLS = 132
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  logic [7:0]        req_start_x,
   input  logic [7:0]        req_start_y,
   input  logic [7:0]        req_end_x,
   input  logic [7:0]        req_end_y,
   input  logic [7:0]        req_fill_value,
   input  logic [7:0]        req_row_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_span_row,
   output logic [7:0]        rsp_span_left,
   output logic signed [8:0] rsp_span_right,
   output logic              rsp_span_valid,
   output logic [7:0]        rsp_span_color
);
   import qsr_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_READ} state_type;

   state_type         state_ff;
   logic              rsp_valid_ff;
   logic [7:0]        row_ff, left_ff, color_ff, fill_color_ff;
   logic signed [8:0] right_ff;
   logic              drawn_ff;

   logic      accept, rsp_free, walk_start, clear, hold;
   point_type walk_pt;
   probe_type probe;
   span_type  span;

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign walk_start = accept && (req_kind == KIND_EDGE);
   assign clear      = accept && (req_kind == KIND_BEGIN);
   assign hold       = (state_ff == S_READ);

   always_comb begin
      if (state_ff == S_WALK) begin
         probe.update = walk_pt.vld;
         probe.row    = walk_pt.row;
         probe.col    = walk_pt.col;
      end else begin
         probe.update = 1'b0;
         probe.row    = req_row_index;
         probe.col    = '0;
      end
   end

   qsr_line_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .start   (walk_start),
      .start_x (req_start_x),
      .start_y (req_start_y),
      .end_x   (req_end_x),
      .end_y   (req_end_y),
      .point   (walk_pt)
   );

   qsr_span_store #(.ROWS(ROWS), .COLS(COLS)) u_store (
      .clock (clock),
      .reset (reset),
      .clear (clear),
      .hold  (hold),
      .probe (probe),
      .span  (span)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         fill_color_ff <= '0;
      end else begin
         // in S_READ the response register is reloaded below instead
         if (rsp_valid_ff && rsp_ready && (state_ff != S_READ)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_kind)
                     KIND_BEGIN: fill_color_ff <= req_fill_value;
                     KIND_EDGE:  state_ff <= S_WALK;
                     KIND_READ: begin
                        if ({1'b0, req_row_index} < 9'(ROWS)) begin
                           state_ff <= S_READ;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_WALK: begin
               if (walk_pt.last) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: state_ff <= S_IDLE;
            S_READ: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  row_ff       <= span.row;
                  left_ff      <= span.left;
                  right_ff     <= span.right;
                  drawn_ff     <= span.drawn;
                  color_ff     <= fill_color_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_span_row   = row_ff;
   assign rsp_span_left  = left_ff;
   assign rsp_span_right = right_ff;
   assign rsp_span_valid = drawn_ff;
   assign rsp_span_color = color_ff;

endmodule

/* hdl/qsr_checker.sv */
// qsr_checker: port-level assertions for quad_span_rasterizer, bound to the top level.
// Depends on qsr_pkg.
module qsr_checker #(
   parameter int ROWS = 132
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [1:0]        req_kind,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [7:0]        rsp_span_row,
   input logic [7:0]        rsp_span_left,
   input logic signed [8:0] rsp_span_right,
   input logic              rsp_span_valid,
   input logic [7:0]        rsp_span_color
);
   import qsr_pkg::*;

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_span_row) &&
         $stable(rsp_span_left) && $stable(rsp_span_right) &&
         $stable(rsp_span_valid) && $stable(rsp_span_color))
      else $error("response changed while stalled");

   a_drawn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_span_valid == (rsp_span_right > $signed({1'b0, rsp_span_left}))))
      else $error("span valid flag disagrees with left/right");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_span_row < ROWS) &&
         (rsp_span_right == -9'sd1 || (rsp_span_right >= 0 && rsp_span_right < ROWS)))
      else $error("response row or right edge out of range");

   // an edge trace always keeps the block busy after its request is accepted
   a_edge_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_EDGE |=> !req_ready)
      else $error("ready after edge request");

endmodule

bind quad_span_rasterizer qsr_checker #(.ROWS(ROWS)) u_qsr_checker (.*);
